// ----- design/rhsv_pkg.sv -----
package rhsv_pkg;

  // Field widths of the pixel and of the result.
  localparam int unsigned ChanW = 8;
  localparam int unsigned HueW  = 15;

  // Hue scale: one sixth of a turn and a full turn in 1/64-degree units.
  localparam logic [15:0] HueSixth = 16'd3840;
  localparam logic [15:0] HueFull  = 16'd23040;

  // Sector offsets for the green and blue sectors (red sector is zero).
  localparam logic [HueW-1:0] OffRed   = 15'd0;
  localparam logic [HueW-1:0] OffGreen = 15'd7680;
  localparam logic [HueW-1:0] OffBlue  = 15'd15360;

  // Divider geometry: 12 quotient bits, numerator up to 20 bits.
  localparam int unsigned QuoW   = 12;
  localparam int unsigned NumW   = QuoW + ChanW;
  localparam int unsigned NumCells = QuoW;

  // One division lane: partial remainder, numerator/quotient shift word and divisor.
  typedef struct packed {
    logic [ChanW-1:0] rem;
    logic [QuoW-1:0]  sh;
    logic [ChanW-1:0] div;
  } lane_t;

  // Everything that travels down the row of divider cells.
  typedef struct packed {
    logic             vld;
    lane_t            hue_l;
    lane_t            sat_l;
    logic [ChanW-1:0] val;
    logic [HueW-1:0]  offset;
    logic             neg;
  } stage_t;

endpackage

// ----- design/rhsv_if.sv -----
// Pixel channel: one RGB pixel per transaction.
interface rhsv_pix_if;
  import rhsv_pkg::*;

  logic             valid;
  logic             ready;
  logic [ChanW-1:0] red;
  logic [ChanW-1:0] green;
  logic [ChanW-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// Result channel: one HSV triple per transaction.
interface rhsv_hsv_if;
  import rhsv_pkg::*;

  logic             valid;
  logic             ready;
  logic [HueW-1:0]  hue;
  logic [ChanW-1:0] saturation;
  logic [ChanW-1:0] value;

  modport source (output valid, output hue, output saturation, output value, input ready);
  modport sink   (input valid, input hue, input saturation, input value, output ready);
endinterface

// ----- design/rhsv_prep.sv -----
module rhsv_prep (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      vld_i,
  input  logic [rhsv_pkg::ChanW-1:0] red_i,
  input  logic [rhsv_pkg::ChanW-1:0] green_i,
  input  logic [rhsv_pkg::ChanW-1:0] blue_i,
  output rhsv_pkg::stage_t          stage_o
);
  import rhsv_pkg::*;

  logic [ChanW-1:0] mx, mn, delta, p, q, diff;
  logic [HueW-1:0]  offset;
  logic             neg;
  logic [NumW-1:0]  num_hue, num_sat;
  stage_t           stage_d, stage_q;

  // Largest and smallest channel, and the sector of the largest one.
  always_comb begin
    mx = (red_i > green_i) ? red_i : green_i;
    mx = (mx > blue_i) ? mx : blue_i;
    mn = (red_i < green_i) ? red_i : green_i;
    mn = (mn < blue_i) ? mn : blue_i;
    delta = mx - mn;
    if (mx == red_i) begin
      p = green_i;
      q = blue_i;
      offset = OffRed;
    end else if (mx == green_i) begin
      p = blue_i;
      q = red_i;
      offset = OffGreen;
    end else begin
      p = red_i;
      q = green_i;
      offset = OffBlue;
    end
    neg  = (p < q);
    diff = neg ? (q - p) : (p - q);
  end

  // Numerators: 3840 * diff (rounded up when negative) and 255 * delta, by shifts.
  always_comb begin
    num_hue = ({diff, 12'd0} - {4'd0, diff, 8'd0})
            + (neg ? {12'd0, delta - 8'd1} : '0);
    num_sat = {4'd0, delta, 8'd0} - {12'd0, delta};
  end

  // Load the first stage of the divider row; a zero divisor becomes one.
  always_comb begin
    stage_d.vld        = vld_i;
    stage_d.hue_l.rem  = num_hue[NumW-1:QuoW];
    stage_d.hue_l.sh   = num_hue[QuoW-1:0];
    stage_d.hue_l.div  = (delta == '0) ? ChanW'(1) : delta;
    stage_d.sat_l.rem  = num_sat[NumW-1:QuoW];
    stage_d.sat_l.sh   = num_sat[QuoW-1:0];
    stage_d.sat_l.div  = (mx == '0) ? ChanW'(1) : mx;
    stage_d.val        = mx;
    stage_d.offset     = offset;
    stage_d.neg        = neg;
  end

  // The stage register clears on reset and holds while the pipeline is stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

// ----- design/rhsv_cell.sv -----
module rhsv_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  rhsv_pkg::stage_t stage_i,
  output rhsv_pkg::stage_t stage_o
);
  import rhsv_pkg::*;

  stage_t stage_d, stage_q;

  // One restoring division step: bring down a numerator bit, subtract if it fits.
  function automatic lane_t div_step(lane_t l);
    logic [ChanW:0] trial;
    logic           ge;
    lane_t          r;
    trial  = {l.rem, l.sh[QuoW-1]};
    ge     = (trial >= {1'b0, l.div});
    r.rem  = ge ? ChanW'(trial - {1'b0, l.div}) : trial[ChanW-1:0];
    r.sh   = {l.sh[QuoW-2:0], ge};
    r.div  = l.div;
    return r;
  endfunction

  // Both lanes advance by one quotient bit; side data rides along.
  always_comb begin
    stage_d       = stage_i;
    stage_d.hue_l = div_step(stage_i.hue_l);
    stage_d.sat_l = div_step(stage_i.sat_l);
  end

  // The stage register clears on reset and holds while the pipeline is stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

// ----- design/rgb_to_hsv_converter.sv -----
// A pixel passes through one operand stage, a row of 12 divider cells and one
// output register. Throughput: one pixel per cycle unless the output is held,
// set by the row of one-bit divider cells.
// When the output is held, the whole pipeline freezes and ready drops.
// Reset is asynchronous and active low; it clears all valid bits at once.
module rgb_to_hsv_converter (
  input  logic             clk_i,
  input  logic             rst_ni,
  rhsv_pix_if.sink         pix_i,
  rhsv_hsv_if.source       hsv_o
);
  import rhsv_pkg::*;

  stage_t          chain [0:NumCells];
  logic            en;
  logic [15:0]     hue_raw, hue_add, hue_wrap;
  logic            out_vld_q;
  logic [HueW-1:0]  hue_q;
  logic [ChanW-1:0] sat_q, val_q;

  // The pipeline advances whenever the output register is free or being drained.
  assign en          = !out_vld_q || hsv_o.ready;
  assign pix_i.ready = en;

  // Operand stage.
  rhsv_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (pix_i.valid),
    .red_i   (pix_i.red),
    .green_i (pix_i.green),
    .blue_i  (pix_i.blue),
    .stage_o (chain[0])
  );

  // Row of divider cells, one quotient bit each.
  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    rhsv_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .stage_i (chain[i]),
      .stage_o (chain[i+1])
    );
  end

  // Hue assembly: add the sector offset, mirror negative quotients and wrap.
  always_comb begin
    hue_add  = chain[NumCells].neg ? (HueFull - {4'd0, chain[NumCells].hue_l.sh})
                                   : {4'd0, chain[NumCells].hue_l.sh};
    hue_raw  = {1'b0, chain[NumCells].offset} + hue_add;
    hue_wrap = (hue_raw >= HueFull) ? (hue_raw - HueFull) : hue_raw;
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= chain[NumCells].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && chain[NumCells].vld) begin
      hue_q <= hue_wrap[HueW-1:0];
      sat_q <= chain[NumCells].sat_l.sh[ChanW-1:0];
      val_q <= chain[NumCells].val;
    end
  end

  assign hsv_o.valid      = out_vld_q;
  assign hsv_o.hue        = hue_q;
  assign hsv_o.saturation = sat_q;
  assign hsv_o.value      = val_q;

endmodule

// ----- design/rhsv_checker.sv -----
module rhsv_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [rhsv_pkg::HueW-1:0]  hue_i,
  input logic [rhsv_pkg::ChanW-1:0] sat_i,
  input logic [rhsv_pkg::ChanW-1:0] val_i
);
  import rhsv_pkg::*;

  // A held result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  // A held result keeps its fields.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(hue_i) && $stable(sat_i) && $stable(val_i))
    else $error("result changed while stalled");

  // With no result pending, the block always takes a new pixel.
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with an empty output register");

  // Zero saturation means a grey pixel, whose hue is zero; hue stays below a full turn.
  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (hue_i < HueFull[HueW-1:0]) && ((sat_i != '0) || (hue_i == '0)))
    else $error("hue out of range or non-zero for a grey pixel");

endmodule

bind rgb_to_hsv_converter rhsv_checker u_rhsv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (pix_i.ready),
  .out_valid_i (hsv_o.valid),
  .out_ready_i (hsv_o.ready),
  .hue_i       (hsv_o.hue),
  .sat_i       (hsv_o.saturation),
  .val_i       (hsv_o.value)
);

// ----- tb/testbench.sv -----
module testbench;
  import rhsv_pkg::*;

  // A pixel waiting to be sent and the HSV triple it should produce.
  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [HueW-1:0]  hue;
    logic [ChanW-1:0] saturation;
    logic [ChanW-1:0] value;
  } hsv_t;

  localparam int unsigned RandomPixels = 450;
  localparam int unsigned IdleLimit    = 2000;
  localparam int unsigned DrainCycles  = 30;
  localparam int unsigned HoldCycles   = 80;

  logic clk_i = 1'b0;
  logic rst_ni;

  rhsv_pix_if pix_bus ();
  rhsv_hsv_if hsv_bus ();

  rgb_to_hsv_converter u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_bus),
    .hsv_o  (hsv_bus)
  );

  pixel_t      pixel_backlog[$];
  hsv_t        hsv_expected[$];
  int unsigned error_count  = 0;
  int unsigned results_seen = 0;
  int unsigned send_gap     = 0;
  int unsigned recv_stall   = 0;
  int unsigned recv_hold    = 0;
  int unsigned idle_cycles  = 0;
  bit          send_calm    = 1'b0;
  bit          recv_calm    = 1'b0;

  always #6 clk_i = ~clk_i;

  // Colour conversion in plain integer arithmetic; hue is floored, also when negative.
  function automatic hsv_t hsv_of(pixel_t px);
    int unsigned r, g, b, hi, lo, span, lead, trail, off, h;
    hsv_t res;
    r  = px.red;
    g  = px.green;
    b  = px.blue;
    hi = (r > g) ? r : g;
    hi = (hi > b) ? hi : b;
    lo = (r < g) ? r : g;
    lo = (lo < b) ? lo : b;
    span = hi - lo;
    h = 0;
    if (span != 0) begin
      // Red wins a tie for the largest channel, then green.
      if (hi == r) begin
        lead = g; trail = b; off = OffRed;
      end else if (hi == g) begin
        lead = b; trail = r; off = OffGreen;
      end else begin
        lead = r; trail = g; off = OffBlue;
      end
      if (lead >= trail) begin
        h = off + (HueSixth * (lead - trail)) / span;
      end else begin
        h = off + HueFull - (HueSixth * (trail - lead) + span - 1) / span;
      end
      if (h >= HueFull) begin
        h = h - HueFull;
      end
    end
    res.hue        = h[HueW-1:0];
    res.saturation = (hi == 0) ? '0 : ChanW'((255 * span) / hi);
    res.value      = hi[ChanW-1:0];
    return res;
  endfunction

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap(bit calm);
    int unsigned roll;
    roll = $urandom_range(99);
    if (calm || roll < 55) begin
      return 0;
    end
    if (roll < 90) begin
      return $urandom_range(3, 1);
    end
    return $urandom_range(40, 10);
  endfunction

  function automatic logic [ChanW-1:0] extreme_chan();
    logic [ChanW-1:0] picks [4];
    picks = '{8'd0, 8'd1, 8'd254, 8'd255};
    return picks[$urandom_range(3)];
  endfunction

  // Random pixels, weighted towards grey, ties, extremes and tiny spans.
  function automatic pixel_t random_pixel();
    int unsigned roll;
    logic [ChanW-1:0] top, other;
    pixel_t px;
    roll = $urandom_range(99);
    px.red   = $urandom_range(255);
    px.green = $urandom_range(255);
    px.blue  = $urandom_range(255);
    if (roll >= 50 && roll < 60) begin
      px.green = px.red;
      px.blue  = px.red;
    end else if (roll >= 60 && roll < 75) begin
      top   = $urandom_range(255);
      other = $urandom_range(top);
      case ($urandom_range(2))
        0: px = '{top, top, other};
        1: px = '{top, other, top};
        default: px = '{other, top, top};
      endcase
    end else if (roll >= 75 && roll < 85) begin
      px = '{extreme_chan(), extreme_chan(), extreme_chan()};
    end else if (roll >= 85) begin
      px.red   = $urandom_range(3);
      px.green = $urandom_range(3);
      px.blue  = $urandom_range(3);
    end
    return px;
  endfunction

  // Stimulus, reset and the end of the run.
  initial begin
    rst_ni = 1'b0;

    // Black, white and grey, the primaries, ties and negative hues in every sector.
    pixel_backlog = '{
      '{8'd0,   8'd0,   8'd0},   '{8'd255, 8'd255, 8'd255}, '{8'd128, 8'd128, 8'd128},
      '{8'd255, 8'd0,   8'd0},   '{8'd0,   8'd255, 8'd0},   '{8'd0,   8'd0,   8'd255},
      '{8'd255, 8'd255, 8'd0},   '{8'd0,   8'd255, 8'd255}, '{8'd255, 8'd0,   8'd255},
      '{8'd255, 8'd0,   8'd1},   '{8'd200, 8'd10,  8'd100}, '{8'd100, 8'd200, 8'd50},
      '{8'd10,  8'd100, 8'd200}, '{8'd1,   8'd0,   8'd0},   '{8'd0,   8'd1,   8'd0},
      '{8'd0,   8'd0,   8'd1},   '{8'd255, 8'd254, 8'd0},   '{8'd1,   8'd1,   8'd0},
      '{8'd254, 8'd255, 8'd255}, '{8'd255, 8'd1,   8'd0},   '{8'd0,   8'd255, 8'd1},
      '{8'd85,  8'd170, 8'd255}, '{8'd1,   8'd0,   8'd1}
    };
    for (int unsigned i = 0; i < RandomPixels; i++) begin
      pixel_backlog.push_back(random_pixel());
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i); while (pixel_backlog.size() != 0 || pix_bus.valid);
    while (hsv_expected.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Pixel driver: records the expected result of each transaction, then idles or offers the next.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pix_bus.valid <= 1'b0;
      pix_bus.red   <= '0;
      pix_bus.green <= '0;
      pix_bus.blue  <= '0;
    end else begin
      if (pix_bus.valid && pix_bus.ready) begin
        hsv_expected.push_back(hsv_of(pixel_t'{pix_bus.red, pix_bus.green, pix_bus.blue}));
        send_gap = pick_gap(send_calm);
        if ($urandom_range(63) == 0) begin
          send_calm = !send_calm;
        end
      end
      if (!pix_bus.valid || pix_bus.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          pix_bus.valid <= 1'b0;
        end else if (pixel_backlog.size() != 0) begin
          pixel_t px;
          px = pixel_backlog.pop_front();
          pix_bus.valid <= 1'b1;
          pix_bus.red   <= px.red;
          pix_bus.green <= px.green;
          pix_bus.blue  <= px.blue;
        end else begin
          pix_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each transaction against the oldest expectation and paces ready.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hsv_bus.ready <= 1'b0;
    end else begin
      if (hsv_bus.valid && hsv_bus.ready) begin
        if (hsv_expected.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result hue=%0d sat=%0d val=%0d", $time,
                   hsv_bus.hue, hsv_bus.saturation, hsv_bus.value);
        end else begin
          hsv_t want;
          want = hsv_expected.pop_front();
          if (hsv_bus.hue !== want.hue) begin
            error_count++;
            $display("%0t: hue expected %0d, got %0d", $time, want.hue, hsv_bus.hue);
          end
          if (hsv_bus.saturation !== want.saturation) begin
            error_count++;
            $display("%0t: saturation expected %0d, got %0d", $time,
                     want.saturation, hsv_bus.saturation);
          end
          if (hsv_bus.value !== want.value) begin
            error_count++;
            $display("%0t: value expected %0d, got %0d", $time, want.value, hsv_bus.value);
          end
        end
        results_seen++;
        // Twice in the run, hold off long enough for the pipeline to fill and stall its input.
        if (results_seen == 100 || results_seen == 300) begin
          recv_hold = HoldCycles;
        end
      end
      if (recv_hold > 0) begin
        recv_hold--;
        hsv_bus.ready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        hsv_bus.ready <= 1'b0;
      end else begin
        hsv_bus.ready <= 1'b1;
        if ($urandom_range(2) == 0) begin
          recv_stall = pick_gap(recv_calm);
        end
        if ($urandom_range(63) == 0) begin
          recv_calm = !recv_calm;
        end
      end
    end
  end

  // Watchdog: ends the run when no transaction happens on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (pix_bus.valid && pix_bus.ready) || (hsv_bus.valid && hsv_bus.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

endmodule

// ----- files.f -----
design/rhsv_pkg.sv
design/rhsv_if.sv
design/rhsv_prep.sv
design/rhsv_cell.sv
design/rgb_to_hsv_converter.sv
design/rhsv_checker.sv
tb/testbench.sv
